// ----- rtl/cs_pkg.sv -----
// cs_pkg: shared types and constants for the comment stripper
// no dependencies

package cs_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;

  localparam logic [1:0] MODE_CODE  = 2'd0;
  localparam logic [1:0] MODE_LINE  = 2'd1;
  localparam logic [1:0] MODE_BLOCK = 2'd2;

  localparam int CNT_W = 24;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0]       held_byte;
    logic             held_keep;
    logic [7:0]       final_byte;
    logic             final_keep;
    logic             is_last;
    logic [CNT_W-1:0] count;
  } rec_t;

endpackage

// ----- rtl/comment_stripper_top.sv -----
// comment_stripper_top: strips line and block comments from a byte stream
// depends on cs_pkg, cs_front, cs_fifo, cs_back
//
// channel   handshake        payload
// input     push / full      in_byte, is_last
// result    empty / pop      out_byte, byte_valid, stream_end, kept_count, run_last
//
// one byte accepted per cycle while the four-entry record queue has room; the
// front judges the held byte in the accept cycle and queues at most one record per byte
// the back emits one result per cycle from the queue head while the receiver pops, so a final byte
// that also releases a held byte yields two results
// a result passes through the record queue and the output register before it is on the ports
// input stalls only while the record queue is full; rst clears the control state, not queue storage or result data

module comment_stripper_top import cs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_byte,
  input  logic             is_last,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             stream_end,
  output logic [CNT_W-1:0] kept_count,
  output logic             run_last
);

  logic q_push;
  logic q_pop;
  logic q_nonempty;
  rec_t q_wr_rec;
  rec_t q_rd_rec;

  cs_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_byte (in_byte),
    .is_last (is_last),
    .q_full  (full),
    .q_push  (q_push),
    .q_rec   (q_wr_rec)
  );

  cs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wr_rec   (q_wr_rec),
    .full     (full),
    .rd       (q_pop),
    .rd_rec   (q_rd_rec),
    .nonempty (q_nonempty)
  );

  cs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_rec      (q_rd_rec),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .stream_end (stream_end),
    .kept_count (kept_count),
    .run_last   (run_last)
  );

  a_end_is_run_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && stream_end) |-> run_last)
    else $error("closing item not marked as run last");

  a_mid_is_kept: assert property (@(posedge clk) disable iff (rst)
    (!empty && !stream_end) |-> byte_valid)
    else $error("non-closing item without a kept byte");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> (out_byte == 8'h00))
    else $error("dropped byte not zeroed");

  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !stream_end) |-> (kept_count == '0))
    else $error("count shown outside closing item");

endmodule

// ----- rtl/cs_front.sv -----
// cs_front: accepts text bytes, judges the held byte and tracks comment mode
// depends on cs_pkg

module cs_front import cs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] in_byte,
  input  logic       is_last,
  input  logic       q_full,
  output logic       q_push,
  output rec_t       q_rec
);

  logic [7:0]       held_byte;
  logic             held_valid;
  logic [7:0]       byte_before_held;
  logic             before_valid;
  logic [1:0]       comment_mode;
  logic [CNT_W-1:0] kept_total;

  logic             accept;
  logic [1:0]       m1, m2, m3, m4;
  logic             keep_h, keep_f;
  logic [1:0]       mode_after;
  logic [CNT_W-1:0] cnt1, cnt2;

  assign accept = push & ~q_full;

  always_comb begin
    m1 = comment_mode;
    if (comment_mode == MODE_CODE && held_byte == CH_SLASH && in_byte == CH_SLASH) begin
      m1 = MODE_LINE;
    end
    m2 = m1;
    if (m1 == MODE_CODE && held_byte == CH_SLASH && in_byte == CH_STAR) begin
      m2 = MODE_BLOCK;
    end
    keep_h = held_valid && (m2 == MODE_CODE || held_byte == CH_NL);
    m3 = m2;
    if (before_valid && m2 == MODE_BLOCK && byte_before_held == CH_STAR &&
        held_byte == CH_SLASH) begin
      m3 = MODE_CODE;
    end
    m4 = m3;
    if (m3 == MODE_LINE && held_byte == CH_NL) begin
      m4 = MODE_CODE;
    end
    mode_after = held_valid ? m4 : comment_mode;
    keep_f     = (mode_after == MODE_CODE);
    cnt1 = (keep_h && kept_total != CNT_MAX) ? kept_total + 1'b1 : kept_total;
    cnt2 = (keep_f && cnt1 != CNT_MAX) ? cnt1 + 1'b1 : cnt1;
  end

  assign q_push = accept & (is_last | keep_h);

  always_comb begin
    q_rec.held_byte  = held_byte;
    q_rec.held_keep  = keep_h;
    q_rec.final_byte = in_byte;
    q_rec.final_keep = keep_f;
    q_rec.is_last    = is_last;
    q_rec.count      = cnt2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_byte        <= '0;
      held_valid       <= 1'b0;
      byte_before_held <= '0;
      before_valid     <= 1'b0;
      comment_mode     <= MODE_CODE;
      kept_total       <= '0;
    end else if (accept) begin
      if (is_last) begin
        held_byte        <= '0;
        held_valid       <= 1'b0;
        byte_before_held <= '0;
        before_valid     <= 1'b0;
        comment_mode     <= MODE_CODE;
        kept_total       <= '0;
      end else begin
        if (held_valid) begin
          byte_before_held <= held_byte;
          before_valid     <= 1'b1;
        end
        held_byte    <= in_byte;
        held_valid   <= 1'b1;
        comment_mode <= mode_after;
        kept_total   <= cnt1;
      end
    end
  end

endmodule

// ----- rtl/cs_fifo.sv -----
// cs_fifo: short record queue between the front and back parts
// depends on cs_pkg

module cs_fifo import cs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  rec_t wr_rec,
  output logic full,
  input  logic rd,
  output rec_t rd_rec,
  output logic nonempty
);

  rec_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              do_wr, do_rd;

  assign full     = (count == (QPTR_W + 1)'(QDEPTH));
  assign nonempty = (count != '0);
  assign do_wr    = wr & ~full;
  assign do_rd    = rd & nonempty;
  assign rd_rec   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/cs_back.sv -----
// cs_back: expands queued records into result items behind an output register
// depends on cs_pkg

module cs_back import cs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_nonempty,
  input  rec_t             q_rec,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             stream_end,
  output logic [CNT_W-1:0] kept_count,
  output logic             run_last
);

  logic ovalid;
  logic phase;
  logic load;
  logic emit_held;

  assign empty     = ~ovalid;
  assign load      = q_nonempty & (~ovalid | pop);
  assign emit_held = q_rec.held_keep & ~phase;
  assign q_pop     = load & (~emit_held | ~q_rec.is_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      phase  <= 1'b0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        phase  <= emit_held & q_rec.is_last;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_held) begin
        out_byte   <= q_rec.held_byte;
        byte_valid <= 1'b1;
        stream_end <= 1'b0;
        kept_count <= '0;
        run_last   <= ~q_rec.is_last;
      end else begin
        out_byte   <= q_rec.final_keep ? q_rec.final_byte : 8'h00;
        byte_valid <= q_rec.final_keep;
        stream_end <= 1'b1;
        kept_count <= q_rec.count;
        run_last   <= 1'b1;
      end
    end
  end

endmodule

// ----- verif/comment_stripper_top_test.sv -----
// comment_stripper_top_test: self-checking bench for the comment stripper, predicts
// each result from its own model of the strip rules and checks it field by field
// depends on cs_pkg and comment_stripper_top

module comment_stripper_top_test import cs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             stream_end;
    logic [CNT_W-1:0] kept_count;
    logic             run_last;
  } result_t;

  typedef logic [7:0] text_q_t[$];

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic             clk;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  logic [7:0]       in_byte = 8'h00;
  logic             is_last = 1'b0;
  logic             empty;
  logic             pop = 1'b0;
  logic [7:0]       out_byte;
  logic             byte_valid;
  logic             stream_end;
  logic [CNT_W-1:0] kept_count;
  logic             run_last;

  // predictor state
  logic [7:0]       held_b;
  logic             held_v;
  logic [7:0]       before_b;
  logic             before_v;
  logic [1:0]       mode;
  logic [CNT_W-1:0] kept_total;

  result_t stripped_q[$];

  bit idle_on = 1'b1;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int n_items = 0;
  int n_streams = 0;
  int n_results = 0;
  int n_errors = 0;
  int stall_cycles = 0;

  comment_stripper_top u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .is_last    (is_last),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .stream_end (stream_end),
    .kept_count (kept_count),
    .run_last   (run_last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_strip_state();
    held_b = 8'h00;
    held_v = 1'b0;
    before_b = 8'h00;
    before_v = 1'b0;
    mode = MODE_CODE;
    kept_total = '0;
  endfunction

  function automatic void bump_kept();
    if (kept_total != CNT_MAX) kept_total = kept_total + 1'b1;
  endfunction

  function automatic void strip_step(logic [7:0] b, logic last);
    result_t res[$];
    result_t r;
    logic keep;
    logic [7:0] h;
    if (held_v) begin
      h = held_b;
      if (mode == MODE_CODE && h == CH_SLASH && b == CH_SLASH) mode = MODE_LINE;
      if (mode == MODE_CODE && h == CH_SLASH && b == CH_STAR) mode = MODE_BLOCK;
      keep = (mode == MODE_CODE) || (h == CH_NL);
      if (before_v && mode == MODE_BLOCK && before_b == CH_STAR && h == CH_SLASH)
        mode = MODE_CODE;
      if (mode == MODE_LINE && h == CH_NL) mode = MODE_CODE;
      if (keep) begin
        bump_kept();
        r = '0;
        r.out_byte = h;
        r.byte_valid = 1'b1;
        res.push_back(r);
      end
      before_b = h;
      before_v = 1'b1;
    end
    if (last) begin
      keep = (mode == MODE_CODE);
      if (keep) bump_kept();
      r = '0;
      r.out_byte = keep ? b : 8'h00;
      r.byte_valid = keep;
      r.stream_end = 1'b1;
      r.kept_count = kept_total;
      res.push_back(r);
      clear_strip_state();
    end else begin
      held_b = b;
      held_v = 1'b1;
    end
    if (res.size() > 0) res[res.size()-1].run_last = 1'b1;
    foreach (res[i]) stripped_q.push_back(res[i]);
  endfunction

  // entered just after a falling edge, returns just after a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    bit taken;
    while (idle_on && $urandom_range(99) < 9) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    is_last <= last;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (!full) begin
        strip_step(b, last);
        n_items++;
        if (last) n_streams++;
        taken = 1'b1;
      end
      @(negedge clk);
    end
  endtask

  task automatic send_stream(input text_q_t text);
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  task automatic send_text(input string s);
    text_q_t text;
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_stream(text);
  endtask

  function automatic text_q_t make_stream();
    text_q_t text;
    string tok;
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(60, 30) : $urandom_range(12, 1);
    while (text.size() < len) begin
      case ($urandom_range(9))
        0: tok = "/";
        1: tok = "*";
        2: tok = "\n";
        3: tok = "//";
        4: tok = "/*";
        5: tok = "*/";
        6: tok = "/*/";
        default: tok = "";
      endcase
      if (tok.len() == 0) begin
        if ($urandom_range(1)) text.push_back(8'($urandom_range(255)));
        else text.push_back(8'(8'h61 + $urandom_range(25)));
      end else begin
        for (int i = 0; i < tok.len(); i++) text.push_back(tok[i]);
      end
    end
    return text;
  endfunction

  task automatic wait_drained();
    push <= 1'b0;
    while (stripped_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_directed();
    send_text("a//c\nb");
    send_text("/*x*/y");
    send_text("/*/q");
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_text("/");
    send_text("//\n");
  endtask

  task automatic test_random_streams(input int target);
    while (n_items < target) send_stream(make_stream());
  endtask

  task automatic test_back_to_back(input int count);
    int stop_at;
    stop_at = n_items + count;
    idle_on = 1'b0;
    while (n_items < stop_at) send_stream(make_stream());
    idle_on = 1'b1;
  endtask

  task automatic test_fill_and_stall();
    int stop_at;
    stop_at = n_items + 40;
    idle_on = 1'b0;
    hold_req++;
    while (n_items < stop_at) send_stream(make_stream());
    idle_on = 1'b1;
  endtask

  always @(negedge clk) begin
    if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= idle_on ? ($urandom_range(99) >= 9) : 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst && pop && !empty) begin
      got.out_byte = out_byte;
      got.byte_valid = byte_valid;
      got.stream_end = stream_end;
      got.kept_count = kept_count;
      got.run_last = run_last;
      n_results++;
      if (stripped_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("unexpected result: byte %h valid %b end %b count %0d last %b",
                   got.out_byte, got.byte_valid, got.stream_end, got.kept_count,
                   got.run_last);
      end else begin
        want = stripped_q.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
            got.stream_end !== want.stream_end || got.kept_count !== want.kept_count ||
            got.run_last !== want.run_last) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"mismatch: exp byte %h valid %b end %b count %0d last %b,",
                      " got byte %h valid %b end %b count %0d last %b"},
                     want.out_byte, want.byte_valid, want.stream_end, want.kept_count,
                     want.run_last, got.out_byte, got.byte_valid, got.stream_end,
                     got.kept_count, got.run_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles with no item moving", stall_cycles);
      $display("comment_stripper_top_test NOT OK");
      $finish;
    end
  end

  initial begin
    clear_strip_state();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_streams(200);
    test_back_to_back(100);
    test_fill_and_stall();
    test_random_streams(450);
    wait_drained();
    if (stripped_q.size() != 0) begin
      n_errors += stripped_q.size();
      $display("%0d results never arrived", stripped_q.size());
    end
    $display("covered %0d items in %0d streams, %0d results checked, %0d mismatches",
             n_items, n_streams, n_results, n_errors);
    $display("included back-to-back traffic and a long receiver hold-off that filled the block");
    if (n_errors == 0) begin
      $display("comment_stripper_top_test OK");
    end else begin
      $display("comment_stripper_top_test NOT OK");
    end
    $finish;
  end

endmodule
